[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the port checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TSR_ASSERT_NXT_NR(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tsr_pkg.sv]
// ----------------------------------------------------------------------------
// Typed stack package
// Operation, status and state codes and the packed result word layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsr_pkg;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned EntryW   = 67;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_ROTATE = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_WRONG_TYPE = 3'd2,
    ST_SHALLOW    = 3'd3,
    ST_FULL       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ROT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [8:0]  depth;
    status_t     status;
    logic [2:0]  type_out;
    logic [63:0] value_out;
  } res_t;

endpackage

[hw/rtl/typed_stack_with_rotate_top.sv]
// ----------------------------------------------------------------------------
// Typed stack with rotate
// LIFO stack of tagged 64-bit entries held in one synchronous memory, with
// push, typed pop, rotate of the top N entries and peek at a depth.
// ----------------------------------------------------------------------------
// Channel   Direction  Word content
// s_axis    in         tuser: func; tdata: tag, value, count
// m_axis    out        tdata: value_out, type_out, status, depth
//
// Push, pop and peek accept the word and issue the memory read in S_IDLE,
// then act on the read data and register the result in S_EXEC.
// Rotate by N (N above one and within the depth) moves one entry per S_ROT
// state through the single memory port pair, then writes the old top in S_FIN.
// Reset clears the entry count and the control state; the memory is not
// cleared. A stalled output only holds the block when a new result is due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_stack_with_rotate_top #(
  parameter int unsigned STACK_CAPACITY = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tag [2:0], value [66:3], count [75:67], zero [79:76]
  input  logic [tsr_pkg::InDataW-1:0]    s_axis_tdata,
  // func [1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // value_out [63:0], type_out [66:64], status [69:67], depth [78:70], zero [79]
  output logic [tsr_pkg::OutDataW-1:0]   m_axis_tdata
);

  import tsr_pkg::*;

  localparam int unsigned AW = (STACK_CAPACITY > 1) ? $clog2(STACK_CAPACITY) : 1;
  localparam int unsigned CW = $clog2(STACK_CAPACITY + 1);
  localparam int unsigned XW = (CW > 9) ? CW : 9;

  state_t            state, state_next;
  logic [CW-1:0]     entry_count, entry_count_next;
  op_t               cmd_func;
  logic [2:0]        cmd_type;
  logic [63:0]       cmd_value;
  logic [8:0]        cmd_count;
  logic [EntryW-1:0] tv, tv_next;
  logic [AW-1:0]     waddr, waddr_next;
  logic [8:0]        left, left_next;
  logic              out_valid, out_valid_next;
  res_t              out_res, out_res_next;

  logic [EntryW-1:0] mem [STACK_CAPACITY];
  logic [EntryW-1:0] rd_data;
  logic              we;
  logic [AW-1:0]     wa, ra;
  logic [EntryW-1:0] wd;

  logic              accept, slot_free;
  op_t               in_func;
  logic [XW-1:0]     ec_x, top_x, in_cnt_x, cnt_x, peek_x, ec_next_x;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid || m_axis_tready;
  assign in_func       = op_t'(s_axis_tuser);

  assign ec_x      = XW'(entry_count);
  assign top_x     = ec_x - XW'(1);
  assign in_cnt_x  = XW'(s_axis_tdata[75:67]);
  assign cnt_x     = XW'(cmd_count);
  assign peek_x    = top_x - in_cnt_x;
  assign ec_next_x = XW'(entry_count_next);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_func  <= in_func;
      cmd_type  <= s_axis_tdata[2:0];
      cmd_value <= s_axis_tdata[66:3];
      cmd_count <= s_axis_tdata[75:67];
    end
    tv      <= tv_next;
    waddr   <= waddr_next;
    left    <= left_next;
    out_res <= out_res_next;
  end

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    tv_next          = tv;
    waddr_next       = waddr;
    left_next        = left;
    out_res_next     = out_res;
    out_valid_next   = out_valid && !m_axis_tready;
    we               = 1'b0;
    wa               = waddr;
    wd               = tv;
    ra               = top_x[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_func == OP_PEEK) begin
          ra = peek_x[AW-1:0];
        end
        if (accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cmd_func == OP_PEEK) begin
          ra = AW'(top_x - cnt_x);
        end
        if (cmd_func == OP_ROTATE && cmd_count > 9'd1 && cnt_x <= ec_x) begin
          tv_next    = rd_data;
          ra         = AW'(top_x - XW'(1));
          waddr_next = top_x[AW-1:0];
          left_next  = cmd_count - 9'd1;
          state_next = S_ROT;
        end else if (slot_free) begin
          out_res_next.value_out = '0;
          out_res_next.type_out  = '0;
          out_res_next.status    = ST_OK;
          unique case (cmd_func)
            OP_PUSH: begin
              if (entry_count == CW'(STACK_CAPACITY)) begin
                out_res_next.status = ST_FULL;
              end else begin
                we               = 1'b1;
                wa               = ec_x[AW-1:0];
                wd               = {cmd_type, cmd_value};
                entry_count_next = entry_count + CW'(1);
              end
            end
            OP_POP: begin
              if (entry_count == '0) begin
                out_res_next.status = ST_EMPTY;
              end else if (rd_data[66:64] != cmd_type) begin
                out_res_next.status = ST_WRONG_TYPE;
              end else begin
                out_res_next.value_out = rd_data[63:0];
                out_res_next.type_out  = rd_data[66:64];
                entry_count_next       = entry_count - CW'(1);
              end
            end
            OP_ROTATE: begin
              if (cmd_count != 9'd0 && cnt_x > ec_x) begin
                out_res_next.status = ST_SHALLOW;
              end
            end
            OP_PEEK: begin
              if (entry_count == '0) begin
                out_res_next.status = ST_EMPTY;
              end else if (cnt_x >= ec_x) begin
                out_res_next.status = ST_SHALLOW;
              end else begin
                out_res_next.value_out = rd_data[63:0];
                out_res_next.type_out  = rd_data[66:64];
              end
            end
            default: begin
            end
          endcase
          out_res_next.depth = ec_next_x[8:0];
          out_valid_next     = 1'b1;
          state_next         = S_IDLE;
        end
      end

      S_ROT: begin
        we         = 1'b1;
        wa         = waddr;
        wd         = rd_data;
        ra         = waddr - AW'(2);
        waddr_next = waddr - AW'(1);
        left_next  = left - 9'd1;
        if (left == 9'd1) begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (slot_free) begin
          we                     = 1'b1;
          wa                     = waddr;
          wd                     = tv;
          out_res_next.value_out = '0;
          out_res_next.type_out  = '0;
          out_res_next.status    = ST_OK;
          out_res_next.depth     = ec_x[8:0];
          out_valid_next         = 1'b1;
          state_next             = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/tsr_checker.sv]
// ----------------------------------------------------------------------------
// Typed stack port checker
// Watches the ports of the typed stack and checks output behaviour over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tsr_pkg::OutDataW-1:0] m_axis_tdata
);

  import tsr_pkg::*;

  res_t res;
  logic out_stall;
  logic res_err;
  logic res_blank;
  logic res_empty;

  assign res       = res_t'(m_axis_tdata[OutDataW-2:0]);
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign res_err   = m_axis_tvalid && res.status != ST_OK;
  assign res_blank = res.value_out == '0 && res.type_out == '0;
  assign res_empty = m_axis_tvalid && res.status == ST_EMPTY;

  `TSR_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid, "output word dropped while stalled")
  `TSR_ASSERT_NXT(a_out_stable, out_stall, $stable(m_axis_tdata), "output word changed while stalled")
  `TSR_ASSERT_IMP(a_err_zero, res_err, res_blank, "error result carries payload")
  `TSR_ASSERT_IMP(a_empty_depth, res_empty, res.depth == '0, "empty status with non-zero depth")
  `TSR_ASSERT_NXT_NR(a_rst_ready, rst, s_axis_tready && !m_axis_tvalid, "block not idle after reset")

endmodule

bind typed_stack_with_rotate_top tsr_checker u_tsr_checker (.*);

[bench/stack_result_checker.sv]
// ----------------------------------------------------------------------------
// Typed stack result checker
// Watches both stream channels of the typed stack. It keeps its own copy of
// the tagged entries and the fill level, predicts one result word for every
// accepted input word, and compares each result word field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_result_checker #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [tsr_pkg::InDataW-1:0]        s_axis_tdata,
  input  logic [1:0]                         s_axis_tuser,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [tsr_pkg::OutDataW-1:0]       m_axis_tdata,
  output int                                 mismatch_count,
  output int                                 results_pending,
  output int                                 stack_level,
  output logic [2:0]                         top_tag
);

  logic [63:0]    entry_value [CAPACITY];
  logic [2:0]     entry_tag   [CAPACITY];
  tsr_pkg::res_t  pending_results [$];

  task automatic predict_stack_op(input tsr_pkg::op_t op, input logic [2:0] tag,
                                  input logic [63:0] value, input int unsigned n,
                                  output tsr_pkg::res_t res);
    int unsigned top_idx;
    logic [63:0] held_value;
    logic [2:0]  held_tag;
    res = '0;
    res.status = tsr_pkg::ST_OK;
    case (op)
      tsr_pkg::OP_PUSH: begin
        if (stack_level >= CAPACITY) begin
          res.status = tsr_pkg::ST_FULL;
        end else begin
          entry_value[stack_level] = value;
          entry_tag[stack_level]   = tag;
          stack_level++;
        end
      end
      tsr_pkg::OP_POP: begin
        if (stack_level == 0) begin
          res.status = tsr_pkg::ST_EMPTY;
        end else if (entry_tag[stack_level-1] != tag) begin
          res.status = tsr_pkg::ST_WRONG_TYPE;
        end else begin
          res.value_out = entry_value[stack_level-1];
          res.type_out  = entry_tag[stack_level-1];
          stack_level--;
        end
      end
      tsr_pkg::OP_ROTATE: begin
        if (n > stack_level) begin
          res.status = tsr_pkg::ST_SHALLOW;
        end else if (n > 1) begin
          // The top entry sinks to depth n-1; the ones beneath it rise by one.
          top_idx    = stack_level - 1;
          held_value = entry_value[top_idx];
          held_tag   = entry_tag[top_idx];
          for (int unsigned i = 0; i + 1 < n; i++) begin
            entry_value[top_idx-i] = entry_value[top_idx-i-1];
            entry_tag[top_idx-i]   = entry_tag[top_idx-i-1];
          end
          entry_value[top_idx-n+1] = held_value;
          entry_tag[top_idx-n+1]   = held_tag;
        end
      end
      default: begin
        if (stack_level == 0) begin
          res.status = tsr_pkg::ST_EMPTY;
        end else if (n >= stack_level) begin
          res.status = tsr_pkg::ST_SHALLOW;
        end else begin
          res.value_out = entry_value[stack_level-1-n];
          res.type_out  = entry_tag[stack_level-1-n];
        end
      end
    endcase
    res.depth = stack_level[8:0];
  endtask

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    tsr_pkg::res_t got;
    tsr_pkg::res_t want;
    tsr_pkg::res_t predicted;
    if (rst) begin
      stack_level     = 0;
      top_tag         = '0;
      mismatch_count  = 0;
      pending_results.delete();
      results_pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(tsr_pkg::res_t)-1:0];
        if (pending_results.size() == 0) begin
          $error("result word %h arrived with no prediction waiting", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("value_out", want.value_out, got.value_out);
          report_field("type_out", 64'(want.type_out), 64'(got.type_out));
          report_field("status", 64'(want.status), 64'(got.status));
          report_field("depth", 64'(want.depth), 64'(got.depth));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_stack_op(tsr_pkg::op_t'(s_axis_tuser), s_axis_tdata[2:0],
                         s_axis_tdata[66:3], s_axis_tdata[75:67], predicted);
        pending_results.push_back(predicted);
        top_tag = (stack_level > 0) ? entry_tag[stack_level-1] : 3'd0;
      end
      results_pending = pending_results.size();
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Typed stack testbench
// Drives push, pop, rotate and peek words into the typed stack: a directed
// opening over the error cases and field extremes, then random traffic that
// fills the stack to capacity and drains it again, with random idling on both
// channels. The checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import tsr_pkg::*;

  localparam int unsigned CAPACITY    = 256;
  localparam int          STALL_LIMIT = 5000;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;

  int          mismatch_count;
  int          results_pending;
  int          stack_level;
  logic [2:0]  top_tag;
  bit          idling_on   = 1'b1;
  int          stall_left  = 0;
  int          quiet_cycles = 0;

  typed_stack_with_rotate_top #(
    .STACK_CAPACITY (CAPACITY)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  stack_result_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .stack_level     (stack_level),
    .top_tag         (top_tag)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 16);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called and returning at a falling edge.
  task automatic send_word(input op_t op, input logic [2:0] tag, input logic [63:0] value,
                           input logic [8:0] n);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, n, value, tag};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_op(input int push_pct, input int pop_pct);
    int          roll;
    int          n;
    logic [2:0]  tag;
    logic [63:0] value;
    roll = $urandom_range(0, 99);
    n    = 0;
    if (roll < push_pct) begin
      tag = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 9))
        0:       value = '1;
        1:       value = '0;
        default: value = {$urandom, $urandom};
      endcase
      send_word(OP_PUSH, tag, value, 9'($urandom_range(0, 256)));
    end else if (roll < push_pct + pop_pct) begin
      tag = (stack_level > 0 && $urandom_range(0, 4) != 0) ? top_tag : 3'($urandom_range(0, 7));
      send_word(OP_POP, tag, {$urandom, $urandom}, 9'($urandom_range(0, 256)));
    end else if (roll[0]) begin
      case ($urandom_range(0, 9))
        0: n = 0;
        1: n = (stack_level < CAPACITY) ? $urandom_range(stack_level + 1, CAPACITY) : CAPACITY;
        2: n = stack_level;
        default: n = (stack_level > 0) ? $urandom_range(1, (stack_level < 8) ? stack_level : 8) : 0;
      endcase
      send_word(OP_ROTATE, 3'($urandom_range(0, 7)), {$urandom, $urandom}, 9'(n));
    end else begin
      if ($urandom_range(0, 4) == 0 || stack_level == 0) begin
        n = $urandom_range(stack_level, CAPACITY);
      end else begin
        n = $urandom_range(0, stack_level - 1);
      end
      send_word(OP_PEEK, 3'($urandom_range(0, 7)), {$urandom, $urandom}, 9'(n));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Error cases on an empty stack.
    send_word(OP_POP, 3'd0, '0, 9'd0);
    send_word(OP_PEEK, 3'd0, '0, 9'd0);
    send_word(OP_ROTATE, 3'd0, '0, 9'd0);
    send_word(OP_ROTATE, 3'd0, '0, 9'd1);
    // Field extremes and the tags beyond the named types.
    send_word(OP_PUSH, 3'd0, 64'h0, 9'd0);
    send_word(OP_PUSH, 3'd5, '1, 9'd256);
    send_word(OP_PUSH, 3'd7, 64'hA5A5_A5A5_A5A5_A5A5, 9'd511);
    send_word(OP_PUSH, 3'd6, 64'h5A5A_5A5A_5A5A_5A5A, 9'd0);
    send_word(OP_PUSH, 3'd1, 64'h8000_0000_0000_0000, 9'd0);
    send_word(OP_POP, 3'd0, '0, 9'd0);
    send_word(OP_PEEK, 3'd0, '0, 9'd0);
    send_word(OP_PEEK, 3'd0, '0, 9'd4);
    send_word(OP_PEEK, 3'd0, '0, 9'd5);
    send_word(OP_PEEK, 3'd0, '0, 9'd256);
    send_word(OP_ROTATE, 3'd0, '0, 9'd1);
    send_word(OP_ROTATE, 3'd0, '0, 9'd5);
    send_word(OP_ROTATE, 3'd0, '0, 9'd6);
    send_word(OP_ROTATE, 3'd0, '0, 9'd256);
    send_word(OP_ROTATE, 3'd0, '0, 9'd3);
    send_word(OP_PEEK, 3'd0, '0, 9'd2);
    send_word(OP_POP, top_tag, '0, 9'd0);
    send_word(OP_POP, top_tag, '0, 9'd0);
    send_word(OP_PUSH, 3'd3, {$urandom, $urandom}, 9'd0);
    send_word(OP_PUSH, 3'd2, {$urandom, $urandom}, 9'd0);
    send_word(OP_PUSH, 3'd4, {$urandom, $urandom}, 9'd0);

    repeat (60) random_op(40, 30);

    // Hold the sender until every result has drained.
    s_axis_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);

    // Fill to capacity, then push, rotate and peek against a full stack.
    while (stack_level < CAPACITY) random_op(85, 5);
    send_word(OP_ROTATE, 3'd0, '0, 9'd256);
    send_word(OP_PEEK, 3'd0, '0, 9'd255);
    send_word(OP_PEEK, 3'd0, '0, 9'd256);
    repeat (8) random_op(70, 0);

    // Drain to empty, then keep popping an empty stack.
    while (stack_level > 0) random_op(5, 80);
    repeat (4) random_op(0, 60);

    idling_on = 1'b0;
    repeat (60) random_op(40, 30);

    s_axis_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[typed_stack_with_rotate_top.f]
+incdir+hw/rtl
hw/rtl/tsr_pkg.sv
hw/rtl/typed_stack_with_rotate_top.sv
hw/rtl/tsr_checker.sv
bench/stack_result_checker.sv
bench/testbench.sv
